@@ rtl/cpc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types and constants of the CORDIC coordinate converter.
// ----------------------------------------------------------------------------
`default_nettype none

package cpc_pkg;

   typedef enum logic {
      CMD_TO_POLAR = 1'b0,
      CMD_TO_CART  = 1'b1
   } command_type;

   typedef struct packed {
      command_type cmd;
      logic        hold;   // special case: value already final, skip rotations
   } ctrl_type;

   localparam int WFRAC        = 20;
   localparam int GAIN_SHIFT   = 10;
   localparam int ATAN_ENTRIES = 24;

   // 1/K in Q30
   localparam logic signed [30:0] INV_GAIN = 31'sd652032874;

   localparam logic [31:0] HALF_TURN         = 32'h8000_0000;
   localparam logic [31:0] QUARTER_TURN      = 32'h4000_0000;
   localparam logic [31:0] NEG_QUARTER_TURN  = 32'hC000_0000;

   // round(atan(2^-i) * 2^31 / pi)
   localparam logic [31:0] ATAN_TABLE [0:ATAN_ENTRIES-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

endpackage

`default_nettype wire

@@ rtl/cpc_prescale.sv @@
// ----------------------------------------------------------------------------
// cpc_prescale
// Gain prescale, special-case detection and half-turn folding (two stages).
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_prescale #(
   parameter int COORD_WIDTH = 17,
   parameter int WORK_WIDTH  = 39
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output      logic                          in_ready,
   input  wire cpc_pkg::command_type          in_command,
   input  wire logic signed [COORD_WIDTH-1:0] in_a,
   input  wire logic signed [COORD_WIDTH-1:0] in_b,
   output      logic                          out_valid,
   input  wire logic                          out_ready,
   output      cpc_pkg::ctrl_type             out_ctrl,
   output      logic signed [WORK_WIDTH-1:0]  out_x,
   output      logic signed [WORK_WIDTH-1:0]  out_y,
   output      logic [31:0]                   out_z
);

   localparam int PW = COORD_WIDTH + 31;
   localparam int MW = COORD_WIDTH + 1;

   // stage A
   logic                          a_valid_ff;
   logic                          a_ready;
   cpc_pkg::ctrl_type             a_ctrl_ff, a_ctrl_in;
   logic                          a_flip_ff, a_flip_in;
   logic signed [PW-1:0]          a_pa_ff, a_pa_in;
   logic signed [PW-1:0]          a_pb_ff, a_pb_in;
   logic signed [MW-1:0]          a_mag_ff, a_mag_in;
   logic [31:0]                   a_z_ff, a_z_in;

   logic                          a_zero, b_zero, a_neg, b_neg, fold;
   logic [31:0]                   ang;
   logic signed [COORD_WIDTH-1:0] sel;
   logic signed [MW-1:0]          sel_ext;

   // stage B
   logic                          b_valid_ff;
   logic                          b_ready;
   cpc_pkg::ctrl_type             b_ctrl_ff;
   logic signed [WORK_WIDTH-1:0]  b_x_ff, b_x_in;
   logic signed [WORK_WIDTH-1:0]  b_y_ff, b_y_in;
   logic [31:0]                   b_z_ff;
   logic signed [WORK_WIDTH-1:0]  px, py;

   assign b_ready  = ~b_valid_ff | out_ready;
   assign a_ready  = ~a_valid_ff | b_ready;
   assign in_ready = a_ready;

   always_comb begin
      a_zero  = (in_a == '0);
      b_zero  = (in_b == '0);
      a_neg   = in_a[COORD_WIDTH-1];
      b_neg   = in_b[COORD_WIDTH-1];
      ang     = 32'(in_b) << (32 - COORD_WIDTH);
      fold    = ($signed(ang) > $signed(cpc_pkg::QUARTER_TURN)) ||
                ($signed(ang) < $signed(cpc_pkg::NEG_QUARTER_TURN));
      sel     = b_zero ? in_a : in_b;
      sel_ext = MW'(sel);
      a_mag_in = sel[COORD_WIDTH-1] ? -sel_ext : sel_ext;

      a_ctrl_in.cmd  = in_command;
      a_ctrl_in.hold = (in_command == cpc_pkg::CMD_TO_POLAR) && (a_zero || b_zero);
      a_pa_in = PW'(in_a) * PW'(cpc_pkg::INV_GAIN);
      a_pb_in = PW'(in_b) * PW'(cpc_pkg::INV_GAIN);

      unique case (in_command)
         cpc_pkg::CMD_TO_POLAR: begin
            a_flip_in = a_neg;
            priority if (a_zero && b_zero) a_z_in = '0;
            else if (b_zero)  a_z_in = a_neg ? cpc_pkg::HALF_TURN : '0;
            else if (a_zero)  a_z_in = b_neg ? cpc_pkg::NEG_QUARTER_TURN
                                              : cpc_pkg::QUARTER_TURN;
            else              a_z_in = a_neg ? cpc_pkg::HALF_TURN : '0;
         end
         cpc_pkg::CMD_TO_CART: begin
            a_flip_in = fold;
            a_z_in    = fold ? (ang ^ cpc_pkg::HALF_TURN) : ang;
         end
         default: begin
            a_flip_in = 1'b0;
            a_z_in    = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_ctrl_ff <= a_ctrl_in;
         a_flip_ff <= a_flip_in;
         a_pa_ff   <= a_pa_in;
         a_pb_ff   <= a_pb_in;
         a_mag_ff  <= a_mag_in;
         a_z_ff    <= a_z_in;
      end
   end

   always_comb begin
      px = WORK_WIDTH'(a_pa_ff >>> cpc_pkg::GAIN_SHIFT);
      py = (a_ctrl_ff.cmd == cpc_pkg::CMD_TO_CART) ? '0
                                                    : WORK_WIDTH'(a_pb_ff >>> cpc_pkg::GAIN_SHIFT);
      if (a_ctrl_ff.hold) begin
         b_x_in = WORK_WIDTH'(a_mag_ff) << cpc_pkg::WFRAC;
         b_y_in = '0;
      end else if (a_flip_ff) begin
         b_x_in = -px;
         b_y_in = -py;
      end else begin
         b_x_in = px;
         b_y_in = py;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_ctrl_ff <= a_ctrl_ff;
         b_x_ff    <= b_x_in;
         b_y_ff    <= b_y_in;
         b_z_ff    <= a_z_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_ctrl  = b_ctrl_ff;
   assign out_x     = b_x_ff;
   assign out_y     = b_y_ff;
   assign out_z     = b_z_ff;

endmodule

`default_nettype wire

@@ rtl/cpc_rotation_stage.sv @@
// ----------------------------------------------------------------------------
// cpc_rotation_stage
// One registered CORDIC micro-rotation, vectoring or rotation mode.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_rotation_stage #(
   parameter int WORK_WIDTH = 39,
   parameter int STAGE      = 0
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output      logic                         in_ready,
   input  wire cpc_pkg::ctrl_type            in_ctrl,
   input  wire logic signed [WORK_WIDTH-1:0] in_x,
   input  wire logic signed [WORK_WIDTH-1:0] in_y,
   input  wire logic [31:0]                  in_z,
   output      logic                         out_valid,
   input  wire logic                         out_ready,
   output      cpc_pkg::ctrl_type            out_ctrl,
   output      logic signed [WORK_WIDTH-1:0] out_x,
   output      logic signed [WORK_WIDTH-1:0] out_y,
   output      logic [31:0]                  out_z
);

   localparam logic [31:0] ATAN = cpc_pkg::ATAN_TABLE[STAGE];

   logic                         valid_ff;
   cpc_pkg::ctrl_type            ctrl_ff;
   logic signed [WORK_WIDTH-1:0] x_ff, x_in;
   logic signed [WORK_WIDTH-1:0] y_ff, y_in;
   logic [31:0]                  z_ff, z_in;
   logic signed [WORK_WIDTH-1:0] xs, ys;

   assign in_ready = ~valid_ff | out_ready;

   always_comb begin
      xs = in_x >>> STAGE;
      ys = in_y >>> STAGE;
      x_in = in_x;
      y_in = in_y;
      z_in = in_z;
      if (!in_ctrl.hold) begin
         unique case (in_ctrl.cmd)
            cpc_pkg::CMD_TO_POLAR: begin
               if (!in_y[WORK_WIDTH-1]) begin
                  x_in = in_x + ys;
                  y_in = in_y - xs;
                  z_in = in_z + ATAN;
               end else begin
                  x_in = in_x - ys;
                  y_in = in_y + xs;
                  z_in = in_z - ATAN;
               end
            end
            cpc_pkg::CMD_TO_CART: begin
               if (!in_z[31]) begin
                  x_in = in_x - ys;
                  y_in = in_y + xs;
                  z_in = in_z - ATAN;
               end else begin
                  x_in = in_x + ys;
                  y_in = in_y - xs;
                  z_in = in_z + ATAN;
               end
            end
            default: begin
               x_in = in_x;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         ctrl_ff <= in_ctrl;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

`default_nettype wire

@@ rtl/cpc_output.sv @@
// ----------------------------------------------------------------------------
// cpc_output
// Rounding, clamping and angle narrowing into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_output #(
   parameter int COORD_WIDTH = 17,
   parameter int WORK_WIDTH  = 39
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output      logic                          in_ready,
   input  wire cpc_pkg::ctrl_type             in_ctrl,
   input  wire logic signed [WORK_WIDTH-1:0]  in_x,
   input  wire logic signed [WORK_WIDTH-1:0]  in_y,
   input  wire logic [31:0]                   in_z,
   output      logic                          out_valid,
   input  wire logic                          out_stall,
   output      logic signed [COORD_WIDTH-1:0] out_a,
   output      logic signed [COORD_WIDTH-1:0] out_b,
   output      logic                          out_sat
);

   localparam int RW = WORK_WIDTH - cpc_pkg::WFRAC;
   localparam int SH = 32 - COORD_WIDTH;

   logic                          valid_ff;
   logic signed [COORD_WIDTH-1:0] a_ff, a_in;
   logic signed [COORD_WIDTH-1:0] b_ff, b_in;
   logic                          sat_ff, sat_in;

   logic signed [WORK_WIDTH-1:0]  half;
   logic signed [RW-1:0]          rx, ry;
   logic                          ovf_x, ovf_y;
   logic signed [COORD_WIDTH-1:0] cx, cy;
   logic [COORD_WIDTH-1:0]        ang;

   assign in_ready = ~valid_ff | ~out_stall;

   generate
      if (SH > 0) begin : g_round_angle
         logic [31:0] zr;
         assign zr  = in_z + (32'd1 << (SH - 1));
         assign ang = zr[31:SH];
      end else begin : g_full_angle
         assign ang = in_z[COORD_WIDTH-1:0];
      end
   endgenerate

   always_comb begin
      half  = WORK_WIDTH'(1) << (cpc_pkg::WFRAC - 1);
      rx    = RW'((in_x + half) >>> cpc_pkg::WFRAC);
      ry    = RW'((in_y + half) >>> cpc_pkg::WFRAC);
      ovf_x = (rx[RW-1:COORD_WIDTH-1] != '0) && (rx[RW-1:COORD_WIDTH-1] != '1);
      ovf_y = (ry[RW-1:COORD_WIDTH-1] != '0) && (ry[RW-1:COORD_WIDTH-1] != '1);
      cx    = ovf_x ? {rx[RW-1], {(COORD_WIDTH-1){~rx[RW-1]}}} : rx[COORD_WIDTH-1:0];
      cy    = ovf_y ? {ry[RW-1], {(COORD_WIDTH-1){~ry[RW-1]}}} : ry[COORD_WIDTH-1:0];
      a_in  = cx;
      unique case (in_ctrl.cmd)
         cpc_pkg::CMD_TO_POLAR: begin
            b_in   = ang;
            sat_in = ovf_x;
         end
         cpc_pkg::CMD_TO_CART: begin
            b_in   = cy;
            sat_in = ovf_x | ovf_y;
         end
         default: begin
            b_in   = cy;
            sat_in = ovf_x;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_sat   = sat_ff;

endmodule

`default_nettype wire

@@ rtl/cartesian_polar_converter_top.sv @@
// ----------------------------------------------------------------------------
// cartesian_polar_converter_top
// Pipelined CORDIC converter between Cartesian and polar coordinates.
// ----------------------------------------------------------------------------
//  Channel  Direction  Ports                                   Handshake
//  req      in         req_command, req_coord_a, req_coord_b   req_valid / req_stall
//  rsp      out        rsp_result_a, rsp_result_b, rsp_saturated rsp_valid / rsp_stall
//
//  One transfer per cycle in each direction when unstalled.
//  Path: two prescale stages, one stage per micro-rotation, and the
//  result register.
//  Every stage holds its own valid bit; empty stages keep filling under stall.
//  Synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_polar_converter_top #(
   parameter int ITERATIONS  = 16,
   parameter int COORD_WIDTH = 17
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic                          req_command,
   input  wire logic signed [COORD_WIDTH-1:0] req_coord_a,
   input  wire logic signed [COORD_WIDTH-1:0] req_coord_b,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic signed [COORD_WIDTH-1:0] rsp_result_a,
   output      logic signed [COORD_WIDTH-1:0] rsp_result_b,
   output      logic                          rsp_saturated
);

   localparam int WORK_WIDTH = COORD_WIDTH + 22;

   logic                         req_ready;
   logic                         valid_c [0:ITERATIONS];
   logic                         ready_c [0:ITERATIONS];
   cpc_pkg::ctrl_type            ctrl_c  [0:ITERATIONS];
   logic signed [WORK_WIDTH-1:0] x_c     [0:ITERATIONS];
   logic signed [WORK_WIDTH-1:0] y_c     [0:ITERATIONS];
   logic [31:0]                  z_c     [0:ITERATIONS];

   assign req_stall = ~req_ready;

   cpc_prescale #(
      .COORD_WIDTH (COORD_WIDTH),
      .WORK_WIDTH  (WORK_WIDTH)
   ) u_prescale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_command (cpc_pkg::command_type'(req_command)),
      .in_a       (req_coord_a),
      .in_b       (req_coord_b),
      .out_valid  (valid_c[0]),
      .out_ready  (ready_c[0]),
      .out_ctrl   (ctrl_c[0]),
      .out_x      (x_c[0]),
      .out_y      (y_c[0]),
      .out_z      (z_c[0])
   );

   generate
      for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
         cpc_rotation_stage #(
            .WORK_WIDTH (WORK_WIDTH),
            .STAGE      (i)
         ) u_stage (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (valid_c[i]),
            .in_ready  (ready_c[i]),
            .in_ctrl   (ctrl_c[i]),
            .in_x      (x_c[i]),
            .in_y      (y_c[i]),
            .in_z      (z_c[i]),
            .out_valid (valid_c[i+1]),
            .out_ready (ready_c[i+1]),
            .out_ctrl  (ctrl_c[i+1]),
            .out_x     (x_c[i+1]),
            .out_y     (y_c[i+1]),
            .out_z     (z_c[i+1])
         );
      end
   endgenerate

   cpc_output #(
      .COORD_WIDTH (COORD_WIDTH),
      .WORK_WIDTH  (WORK_WIDTH)
   ) u_output (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_c[ITERATIONS]),
      .in_ready  (ready_c[ITERATIONS]),
      .in_ctrl   (ctrl_c[ITERATIONS]),
      .in_x      (x_c[ITERATIONS]),
      .in_y      (y_c[ITERATIONS]),
      .in_z      (z_c[ITERATIONS]),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_a     (rsp_result_a),
      .out_b     (rsp_result_b),
      .out_sat   (rsp_saturated)
   );

endmodule

`default_nettype wire
